/* src/p2c_pkg.sv */
// p2c_pkg: shared types, codes, widths and the cordic arctangent table
// for the polar to cartesian regridder; no dependencies
`default_nettype none

package p2c_pkg;

  // item action codes
  typedef enum logic [1:0] {
    ACT_LOAD_RADIUS = 2'd0,
    ACT_LOAD_ANGLE  = 2'd1,
    ACT_LOAD_CELL   = 2'd2,
    ACT_QUERY       = 2'd3
  } act_t;

  // configuration register indexes
  localparam logic [1:0] CFG_RADIUS_COUNT = 2'd0;
  localparam logic [1:0] CFG_ANGLE_COUNT  = 2'd1;
  localparam logic [6:0] COUNT_RESET      = 7'd64;

  // datapath widths
  localparam int CX_W  = 52;  // cordic x/y, 16 fraction bits
  localparam int Z_W   = 36;  // cordic angle, Q2.30 plus headroom
  localparam int RAD_W = 34;  // rounded radius, unsigned
  localparam int KEY_W = 35;  // signed search key

  localparam logic signed [Z_W-1:0] PI_Q30    = 36'sd3373259426;
  localparam logic [31:0]           GAIN_Q32  = 32'h9B74EDA8;

  // one accepted transaction, classified
  typedef struct packed {
    act_t               action;
    logic [15:0]        slot;
    logic               slot_ok;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic signed [31:0] density;
    logic signed [31:0] pressure;
    logic signed [31:0] vel_r;
    logic signed [31:0] vel_a;
    logic signed [31:0] vel_z;
  } item_t;

  // atan(2^-i) in Q2.30, truncated except entries 27 to 30, which are rounded
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/p2c_if.sv */
// p2c channel interfaces: input items, results and configuration writes
// standalone, no package needed
`default_nettype none

interface p2c_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [15:0]        slot;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic signed [31:0] density_in;
  logic signed [31:0] pressure_in;
  logic signed [31:0] vel_radial_in;
  logic signed [31:0] vel_angular_in;
  logic signed [31:0] vel_axial_in;
  modport source(output valid, action, slot, first_value, second_value, density_in,
                 pressure_in, vel_radial_in, vel_angular_in, vel_axial_in,
                 input ready);
  modport sink(input valid, action, slot, first_value, second_value, density_in,
               pressure_in, vel_radial_in, vel_angular_in, vel_axial_in,
               output ready);
endinterface

interface p2c_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        point_slot;
  logic [5:0]         radius_index;
  logic [5:0]         angle_index;
  logic signed [31:0] density_out;
  logic signed [31:0] pressure_out;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  modport source(output valid, point_slot, radius_index, angle_index, density_out,
                 pressure_out, vel_x, vel_y, vel_z, input ready);
  modport sink(input valid, point_slot, radius_index, angle_index, density_out,
               pressure_out, vel_x, vel_y, vel_z, output ready);
endinterface

interface p2c_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/polar_to_cartesian_regrid.sv */
// polar_to_cartesian_regrid: top level, front queue plus back end
// depends on p2c_pkg, the p2c interfaces, p2c_front and p2c_back
//
// Nearest-neighbor resampler from a polar cell grid to cartesian points. Load
// transactions fill the radius axis, the angle axis and the cell store; they
// are written from the queue while the back end is idle and give no result. A
// query transaction goes through these steps: taking it, the vectoring cordic
// steps, gain correction and rounding, two binary searches run side by side,
// each one memory probe per cycle, a cell read, the velocity products and
// sums, then a restoring divide by the radius that yields one quotient bit per
// cycle, and saturation; a zero radius skips the divide and saturation. One
// query is in the back end at a time; a two-entry queue in front keeps taking
// transactions while it has room, and a result register lets the next query
// start while a result waits. Axis and cell memories read as unknown until
// written. No clearing pass after reset.
`default_nettype none

module polar_to_cartesian_regrid #(
  parameter int MAX_RADII = 64,
  parameter int MAX_ANGLES = 64,
  parameter int CORDIC_STEPS = 20
) (
  input  wire logic clk,
  input  wire logic rst_n,
  p2c_in_if.sink    in_ch,
  p2c_out_if.source out_ch,
  p2c_cfg_if.sink   cfg_ch
);
  import p2c_pkg::*;

  localparam int RCW = $clog2(MAX_RADII + 1);
  localparam int ACW = $clog2(MAX_ANGLES + 1);

  item_t q_item;
  logic q_valid;
  logic q_pop;
  logic [RCW-1:0] nr;
  logic [ACW-1:0] na;

  // front: accept, classify, queue
  p2c_front #(.MAX_RADII(MAX_RADII), .MAX_ANGLES(MAX_ANGLES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_ch(cfg_ch),
    .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop), .nr(nr), .na(na)
  );

  // back: loads and queries
  p2c_back #(
    .MAX_RADII(MAX_RADII), .MAX_ANGLES(MAX_ANGLES), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
    .nr(nr), .na(na), .out_ch(out_ch)
  );

endmodule

`default_nettype wire

/* src/p2c_ram.sv */
// p2c_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module p2c_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/p2c_search.sv */
// p2c_search: axis memory with a sequential nearest-entry binary search
// depends on p2c_pkg and p2c_ram
`default_nettype none

module p2c_search #(
  parameter int DEPTH = 64,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              wr_en,
  input  wire logic [IW-1:0]                     wr_addr,
  input  wire logic [31:0]                       wr_data,
  input  wire logic                              start,
  input  wire logic signed [p2c_pkg::KEY_W-1:0]  key,
  input  wire logic [CW-1:0]                     count,
  output logic                                   done,
  output logic [IW-1:0]                          idx
);
  import p2c_pkg::*;

  typedef enum logic [4:0] {
    SR_IDLE  = 5'b00001,
    SR_FIRST = 5'b00010,
    SR_LAST  = 5'b00100,
    SR_MID   = 5'b01000,
    SR_FIN   = 5'b10000
  } sr_state_t;

  sr_state_t state_r, state_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, idx_r, idx_nxt;
  logic signed [KEY_W-1:0] vlo_r, vlo_nxt, vhi_r, vhi_nxt, key_r, key_nxt;
  logic done_r, done_nxt;
  logic [IW-1:0] last, raddr, lo_c, hi_c;
  logic [31:0] rdata;
  logic signed [KEY_W-1:0] axv;
  logic [IW:0] mid_sum;
  logic signed [KEY_W:0] dlo, dhi;

  p2c_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr(raddr), .rdata(rdata)
  );

  assign last = IW'(count - CW'(1));
  assign axv  = {{(KEY_W-32){rdata[31]}}, rdata};
  assign dlo  = (KEY_W+1)'(key_r) - (KEY_W+1)'(vlo_r);
  assign dhi  = (KEY_W+1)'(vhi_r) - (KEY_W+1)'(key_r);

  // bracket after the current probe
  always_comb begin
    lo_c = lo_r;
    hi_c = hi_r;
    if (state_r == SR_LAST) begin
      lo_c = '0;
      hi_c = last;
    end else if (state_r == SR_MID) begin
      if (axv <= key_r) begin
        lo_c = mid_r;
      end else begin
        hi_c = mid_r;
      end
    end
    mid_sum = ({1'b0, lo_c} + {1'b0, hi_c}) >> 1;
  end

  // probe address
  always_comb begin
    case (state_r)
      SR_FIRST: raddr = last;
      SR_LAST:  raddr = mid_sum[IW-1:0];
      SR_MID:   raddr = mid_sum[IW-1:0];
      default:  raddr = '0;
    endcase
  end

  // search sequencer
  always_comb begin
    state_nxt = state_r;
    lo_nxt = lo_c;
    hi_nxt = hi_c;
    mid_nxt = mid_sum[IW-1:0];
    vlo_nxt = vlo_r;
    vhi_nxt = vhi_r;
    key_nxt = key_r;
    idx_nxt = idx_r;
    done_nxt = done_r;
    case (state_r)
      SR_IDLE: begin
        if (start) begin
          key_nxt = key;
          done_nxt = 1'b0;
          state_nxt = SR_FIRST;
        end
      end
      SR_FIRST: begin
        if (key_r <= axv) begin
          idx_nxt = '0;
          done_nxt = 1'b1;
          state_nxt = SR_IDLE;
        end else begin
          vlo_nxt = axv;
          state_nxt = SR_LAST;
        end
      end
      SR_LAST: begin
        if (key_r >= axv) begin
          idx_nxt = last;
          done_nxt = 1'b1;
          state_nxt = SR_IDLE;
        end else begin
          vhi_nxt = axv;
          state_nxt = (hi_c - lo_c > IW'(1)) ? SR_MID : SR_FIN;
        end
      end
      SR_MID: begin
        if (axv <= key_r) begin
          vlo_nxt = axv;
        end else begin
          vhi_nxt = axv;
        end
        state_nxt = (hi_c - lo_c > IW'(1)) ? SR_MID : SR_FIN;
      end
      SR_FIN: begin
        // tie goes to the lower entry
        idx_nxt = (dlo <= dhi) ? lo_r : hi_r;
        done_nxt = 1'b1;
        state_nxt = SR_IDLE;
      end
      default: state_nxt = SR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SR_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    mid_r <= mid_nxt;
    vlo_r <= vlo_nxt;
    vhi_r <= vhi_nxt;
    key_r <= key_nxt;
    idx_r <= idx_nxt;
  end

  assign done = done_r;
  assign idx = idx_r;

endmodule

`default_nettype wire

/* src/p2c_front.sv */
// p2c_front: accepts and classifies transactions into a two-entry queue,
// holds the count registers; depends on p2c_pkg and the p2c interfaces
`default_nettype none

module p2c_front #(
  parameter int MAX_RADII = 64,
  parameter int MAX_ANGLES = 64,
  localparam int RCW = $clog2(MAX_RADII + 1),
  localparam int ACW = $clog2(MAX_ANGLES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  p2c_in_if.sink             in_ch,
  p2c_cfg_if.sink            cfg_ch,
  output p2c_pkg::item_t     q_item,
  output logic               q_valid,
  input  wire logic          q_pop,
  output logic [RCW-1:0]     nr,
  output logic [ACW-1:0]     na
);
  import p2c_pkg::*;

  localparam int CELL_DEPTH = MAX_RADII * MAX_ANGLES;

  item_t fifo_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic push;
  item_t cls;
  logic [6:0] rcount_r, acount_r;

  // classify the incoming transaction
  always_comb begin
    cls.action = act_t'(in_ch.action);
    cls.slot = in_ch.slot;
    cls.first_value = in_ch.first_value;
    cls.second_value = in_ch.second_value;
    cls.density = in_ch.density_in;
    cls.pressure = in_ch.pressure_in;
    cls.vel_r = in_ch.vel_radial_in;
    cls.vel_a = in_ch.vel_angular_in;
    cls.vel_z = in_ch.vel_axial_in;
    case (act_t'(in_ch.action))
      ACT_LOAD_RADIUS: cls.slot_ok = 32'(in_ch.slot) < MAX_RADII;
      ACT_LOAD_ANGLE:  cls.slot_ok = 32'(in_ch.slot) < MAX_ANGLES;
      ACT_LOAD_CELL:   cls.slot_ok = 32'(in_ch.slot) < CELL_DEPTH;
      default:         cls.slot_ok = 1'b1;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = fifo_r[rd_ptr_r];

  // queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

  // count registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcount_r <= COUNT_RESET;
      acount_r <= COUNT_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_RADIUS_COUNT) begin
        rcount_r <= cfg_ch.data;
      end else if (cfg_ch.index == CFG_ANGLE_COUNT) begin
        acount_r <= cfg_ch.data;
      end
    end
  end

  // counts in use, clamped to 1..max
  always_comb begin
    if (rcount_r == 7'd0) begin
      nr = RCW'(1);
    end else if (32'(rcount_r) > MAX_RADII) begin
      nr = RCW'(MAX_RADII);
    end else begin
      nr = RCW'(rcount_r);
    end
    if (acount_r == 7'd0) begin
      na = ACW'(1);
    end else if (32'(acount_r) > MAX_ANGLES) begin
      na = ACW'(MAX_ANGLES);
    end else begin
      na = ACW'(acount_r);
    end
  end

endmodule

`default_nettype wire

/* src/p2c_back.sv */
// p2c_back: executes loads and queries: cordic, axis searches, cell read,
// velocity rotation and divide; depends on p2c_pkg, p2c_ram, p2c_search
`default_nettype none

module p2c_back #(
  parameter int MAX_RADII = 64,
  parameter int MAX_ANGLES = 64,
  parameter int CORDIC_STEPS = 20,
  localparam int RCW = $clog2(MAX_RADII + 1),
  localparam int ACW = $clog2(MAX_ANGLES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire p2c_pkg::item_t    q_item,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire logic [RCW-1:0]    nr,
  input  wire logic [ACW-1:0]    na,
  p2c_out_if.source              out_ch
);
  import p2c_pkg::*;

  localparam int RIW = $clog2(MAX_RADII);
  localparam int AIW = $clog2(MAX_ANGLES);
  localparam int CD  = MAX_RADII * MAX_ANGLES;
  localparam int CAW = $clog2(CD);
  localparam int SW  = $clog2(CORDIC_STEPS);

  typedef enum logic [10:0] {
    B_IDLE  = 11'b00000000001,
    B_CORD  = 11'b00000000010,
    B_GAIN  = 11'b00000000100,
    B_ROUND = 11'b00000001000,
    B_SRCH  = 11'b00000010000,
    B_CELL  = 11'b00000100000,
    B_MULT  = 11'b00001000000,
    B_SUMS  = 11'b00010000000,
    B_DIV   = 11'b00100000000,
    B_SAT   = 11'b01000000000,
    B_DONE  = 11'b10000000000
  } b_state_t;

  b_state_t state_r;
  logic signed [CX_W-1:0] cx_r, cy_r;
  logic signed [Z_W-1:0] z_r;
  logic [SW-1:0] step_r;
  logic orig_r;
  logic signed [31:0] x_r, y_r;
  logic [15:0] slot_r;
  logic [50:0] phi_r;
  logic [63:0] plo_r;
  logic [RAD_W-1:0] rad_r;
  logic signed [KEY_W-1:0] rkey_r, akey_r;
  logic start_r;
  logic signed [63:0] prx_r, pay_r, pry_r, pax_r;
  logic signed [31:0] dens_r, pres_r, vr_r, vz_r;
  logic [63:0] dvdx_r, dvdy_r;
  logic [RAD_W-1:0] remx_r, remy_r;
  logic negx_r, negy_r;
  logic [5:0] div_cnt_r;
  logic signed [31:0] vx_r, vy_r;
  logic out_valid_r;
  logic [15:0] o_slot_r;
  logic [5:0] o_ri_r, o_ai_r;
  logic signed [31:0] o_dens_r, o_pres_r, o_vx_r, o_vy_r, o_vz_r;

  logic r_done, a_done;
  logic [RIW-1:0] ri;
  logic [AIW-1:0] ai;
  logic [CAW-1:0] cell_addr;
  logic [159:0] cell_rd, cell_wd;
  logic cell_we, rad_we, ang_we;
  logic signed [CX_W-1:0] dx, dy, cx0;
  logic signed [Z_W-1:0] at, z0;
  logic [50:0] mpos;
  logic [51:0] psum;
  logic [51:0] radw;
  logic signed [Z_W-1:0] zr;
  logic signed [31:0] c_vr, c_va;
  logic signed [63:0] numx, numy;
  logic [63:0] magx, magy;
  logic [RAD_W:0] trx, try_;
  logic gex, gey;
  logic [31:0] ri32, ai32;

  // loads go straight from the queue
  assign q_pop  = (state_r == B_IDLE) && q_valid;
  assign rad_we = q_pop && q_item.action == ACT_LOAD_RADIUS && q_item.slot_ok;
  assign ang_we = q_pop && q_item.action == ACT_LOAD_ANGLE && q_item.slot_ok;
  assign cell_we = q_pop && q_item.action == ACT_LOAD_CELL && q_item.slot_ok;
  assign cell_wd = {q_item.density, q_item.pressure, q_item.vel_r, q_item.vel_a,
                    q_item.vel_z};

  p2c_search #(.DEPTH(MAX_RADII)) u_rsrch (
    .clk(clk), .rst_n(rst_n), .wr_en(rad_we), .wr_addr(q_item.slot[RIW-1:0]),
    .wr_data(q_item.first_value), .start(start_r), .key(rkey_r),
    .count(nr), .done(r_done), .idx(ri)
  );

  p2c_search #(.DEPTH(MAX_ANGLES)) u_asrch (
    .clk(clk), .rst_n(rst_n), .wr_en(ang_we), .wr_addr(q_item.slot[AIW-1:0]),
    .wr_data(q_item.first_value), .start(start_r), .key(akey_r),
    .count(na), .done(a_done), .idx(ai)
  );

  // cell number is radius index times angle count plus angle index
  assign cell_addr = CAW'(32'(ri) * 32'(na) + 32'(ai));

  p2c_ram #(.WIDTH(160), .DEPTH(CD)) u_cells (
    .clk(clk), .we(cell_we), .waddr(q_item.slot[CAW-1:0]), .wdata(cell_wd),
    .raddr(cell_addr), .rdata(cell_rd)
  );

  // cordic start: fold the left half plane over
  always_comb begin
    cx0 = {{(CX_W-48){q_item.first_value[31]}}, q_item.first_value, 16'h0};
    z0 = '0;
    if (q_item.first_value[31]) begin
      cx0 = -cx0;
      z0 = q_item.second_value[31] ? -PI_Q30 : PI_Q30;
    end
  end

  // one vectoring step
  assign dx = cy_r >>> step_r;
  assign dy = cx_r >>> step_r;
  assign at = {{(Z_W-30){1'b0}}, atan_q30(5'(step_r))};

  // gain correction and rounding
  assign mpos = cx_r[CX_W-1] ? '0 : cx_r[CX_W-2:0];
  assign psum = 52'(phi_r) + 52'(plo_r[63:32]);
  assign radw = (psum + 52'd32768) >> 16;
  assign zr = z_r + Z_W'(8192);

  // cell fields
  assign c_vr = cell_rd[95:64];
  assign c_va = cell_rd[63:32];

  // numerators and magnitudes
  assign numx = prx_r - pay_r;
  assign numy = pry_r + pax_r;
  assign magx = numx[63] ? 64'(-numx) : 64'(numx);
  assign magy = numy[63] ? 64'(-numy) : 64'(numy);

  // restoring divide, one quotient bit per cycle in each lane
  assign trx = {remx_r, dvdx_r[63]};
  assign try_ = {remy_r, dvdy_r[63]};
  assign gex = trx >= {1'b0, rad_r};
  assign gey = try_ >= {1'b0, rad_r};

  assign ri32 = 32'(ri);
  assign ai32 = 32'(ai);

  // query sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_pop && q_item.action == ACT_QUERY) begin
            state_r <= B_CORD;
          end
        end
        B_CORD: begin
          if (step_r == SW'(CORDIC_STEPS - 1)) begin
            state_r <= B_GAIN;
          end
        end
        B_GAIN: state_r <= B_ROUND;
        B_ROUND: begin
          start_r <= 1'b1;
          state_r <= B_SRCH;
        end
        B_SRCH: begin
          if (!start_r && r_done && a_done) begin
            state_r <= B_CELL;
          end
        end
        B_CELL: state_r <= B_MULT;
        B_MULT: state_r <= B_SUMS;
        B_SUMS: state_r <= (rad_r == '0) ? B_DONE : B_DIV;
        B_DIV: begin
          if (div_cnt_r == 6'd63) begin
            state_r <= B_SAT;
          end
        end
        B_SAT: state_r <= B_DONE;
        B_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        cx_r <= cx0;
        cy_r <= q_item.first_value[31] ?
                -{{(CX_W-48){q_item.second_value[31]}}, q_item.second_value, 16'h0} :
                {{(CX_W-48){q_item.second_value[31]}}, q_item.second_value, 16'h0};
        z_r <= z0;
        step_r <= '0;
        orig_r <= (q_item.first_value == '0) && (q_item.second_value == '0);
        x_r <= q_item.first_value;
        y_r <= q_item.second_value;
        slot_r <= q_item.slot;
      end
      B_CORD: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          z_r <= z_r + at;
        end else begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          z_r <= z_r - at;
        end
        step_r <= step_r + SW'(1);
      end
      B_GAIN: begin
        phi_r <= 51'(mpos[50:32]) * 51'(GAIN_Q32);
        plo_r <= 64'(mpos[31:0]) * 64'(GAIN_Q32);
      end
      B_ROUND: begin
        // the origin maps to radius zero and angle zero
        if (orig_r) begin
          rad_r <= '0;
          rkey_r <= '0;
          akey_r <= '0;
        end else begin
          rad_r <= radw[RAD_W-1:0];
          rkey_r <= KEY_W'({1'b0, radw[RAD_W-1:0]});
          akey_r <= {{(KEY_W-(Z_W-14)){zr[Z_W-1]}}, zr[Z_W-1:14]};
        end
      end
      B_MULT: begin
        prx_r <= 64'(c_vr) * 64'(x_r);
        pay_r <= 64'(c_va) * 64'(y_r);
        pry_r <= 64'(c_vr) * 64'(y_r);
        pax_r <= 64'(c_va) * 64'(x_r);
        dens_r <= cell_rd[159:128];
        pres_r <= cell_rd[127:96];
        vr_r <= c_vr;
        vz_r <= cell_rd[31:0];
      end
      B_SUMS: begin
        negx_r <= numx[63];
        negy_r <= numy[63];
        dvdx_r <= magx + 64'(rad_r >> 1);
        dvdy_r <= magy + 64'(rad_r >> 1);
        remx_r <= '0;
        remy_r <= '0;
        div_cnt_r <= '0;
        // zero radius passes the radial velocity through
        vx_r <= vr_r;
        vy_r <= '0;
      end
      B_DIV: begin
        remx_r <= gex ? RAD_W'(trx - {1'b0, rad_r}) : RAD_W'(trx);
        remy_r <= gey ? RAD_W'(try_ - {1'b0, rad_r}) : RAD_W'(try_);
        dvdx_r <= {dvdx_r[62:0], gex};
        dvdy_r <= {dvdy_r[62:0], gey};
        div_cnt_r <= div_cnt_r + 6'd1;
      end
      B_SAT: begin
        if (negx_r) begin
          vx_r <= (dvdx_r >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - dvdx_r);
        end else begin
          vx_r <= (dvdx_r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dvdx_r[31:0];
        end
        if (negy_r) begin
          vy_r <= (dvdy_r >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - dvdy_r);
        end else begin
          vy_r <= (dvdy_r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dvdy_r[31:0];
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == B_DONE && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (state_r == B_DONE && (!out_valid_r || out_ch.ready)) begin
      o_slot_r <= slot_r;
      o_ri_r <= ri32[5:0];
      o_ai_r <= ai32[5:0];
      o_dens_r <= dens_r;
      o_pres_r <= pres_r;
      o_vx_r <= vx_r;
      o_vy_r <= vy_r;
      o_vz_r <= vz_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.point_slot = o_slot_r;
  assign out_ch.radius_index = o_ri_r;
  assign out_ch.angle_index = o_ai_r;
  assign out_ch.density_out = o_dens_r;
  assign out_ch.pressure_out = o_pres_r;
  assign out_ch.vel_x = o_vx_r;
  assign out_ch.vel_y = o_vy_r;
  assign out_ch.vel_z = o_vz_r;

endmodule

`default_nettype wire

/* src/p2c_checker.sv */
// p2c_checker: port-level assertions for the regridder, bound to the top
// depends on polar_to_cartesian_regrid ports only
`default_nettype none

module p2c_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_point_slot,
  input wire logic [31:0] out_vel_x,
  input wire logic        cfg_ready
);

  // a stalled result keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its point slot and x velocity
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_point_slot) && $stable(out_vel_x))
    else $error("result payload changed while stalled");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("configuration port stalled");

endmodule

bind polar_to_cartesian_regrid p2c_checker u_p2c_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_point_slot(out_ch.point_slot),
  .out_vel_x(out_ch.vel_x),
  .cfg_ready(cfg_ch.ready)
);

`default_nettype wire
